FILE: rtl/sbfl_pkg.sv
// Package for the slab block free-list allocator: constants, codes and item types.
package sbfl_pkg;

    // Slab geometry.
    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // Field widths of the item payloads and the configuration registers.
    localparam int SIZE_W  = 32;
    localparam int OFF_W   = 42;
    localparam int BCNT_W  = 11;
    localparam int CFG_W   = 32;
    localparam int STEP_W  = $clog2(SIZE_W);

    // Register reset values.
    localparam logic [BCNT_W-1:0] BLOCK_COUNT_RESET = BCNT_W'(1024);
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET  = SIZE_W'(4096);

    // Configuration register indexes.
    typedef enum logic
    {
        CFG_BLOCK_COUNT = 1'b0,
        CFG_BLOCK_SIZE  = 1'b1
    } cfg_idx_t;

    // Request opcodes.
    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    // Result status codes.
    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_SIZE      = 3'd2,
        ST_ALIGN     = 3'd3,
        ST_EXHAUSTED = 3'd4,
        ST_BAD_FREE  = 3'd5
    } status_t;

    // Operation applied to every cell of the stack chain.
    typedef enum logic [1:0]
    {
        STK_HOLD = 2'd0,
        STK_PUSH = 2'd1,
        STK_POP  = 2'd2
    } stk_op_t;

    // Control states of the top level.
    typedef enum logic [1:0]
    {
        S_IDLE = 2'd0,
        S_REM  = 2'd1,
        S_EXEC = 2'd2,
        S_OUT  = 2'd3
    } state_t;

    // Input item.
    typedef struct packed
    {
        opcode_t           opcode;
        logic [SIZE_W-1:0] request_size;
        logic [SIZE_W-1:0] alignment;
        logic [IDX_W-1:0]  free_index;
    } req_t;

    // Result item.
    typedef struct packed
    {
        status_t          status;
        logic [IDX_W-1:0] block_index;
        logic [OFF_W-1:0] block_offset;
    } rsp_t;

    // Status of the remainder unit.
    typedef struct packed
    {
        logic done;
        logic zero;
    } rem_stat_t;

endpackage

FILE: rtl/sbfl_cell.sv
// One cell of the free-index stack chain: holds one entry and shifts with its neighbors.
module sbfl_cell
    import sbfl_pkg::*;
(
    input  logic             clk,
    input  stk_op_t          op,
    input  logic [IDX_W-1:0] left_data,
    input  logic [IDX_W-1:0] right_data,
    output logic [IDX_W-1:0] data
);

    logic [IDX_W-1:0] data_reg;
    logic [IDX_W-1:0] data_next;

    // A push takes the entry from the cell nearer the top, a pop from the cell below.
    always_comb
    begin
        case (op)
            STK_PUSH: data_next = left_data;
            STK_POP:  data_next = right_data;
            default:  data_next = data_reg;
        endcase
    end

    // Entry storage; contents are undefined until pushed, so no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: rtl/sbfl_stack.sv
// LIFO stack of freed block indexes built as a chain of shifting cells, top at cell 0.
module sbfl_stack
    import sbfl_pkg::*;
(
    input  logic             clk,
    input  stk_op_t          op,
    input  logic [IDX_W-1:0] push_data,
    output logic [IDX_W-1:0] top_data
);

    logic [IDX_W-1:0] cell_data [MAX_BLOCKS];

    // Every cell sees the same operation and trades entries with both neighbors.
    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        logic [IDX_W-1:0] left_d;
        logic [IDX_W-1:0] right_d;

        if (i == 0)
        begin : g_top
            assign left_d = push_data;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        // The bottom cell keeps its entry on a pop; it is beyond the fill level then.
        if (i == MAX_BLOCKS - 1)
        begin : g_bottom
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        sbfl_cell u_cell
        (
            .clk        (clk),
            .op         (op),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    assign top_data = cell_data[0];

endmodule

FILE: rtl/sbfl_rem.sv
// Bit-serial restoring remainder unit: tests whether the alignment divides the block size.
module sbfl_rem
    import sbfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SIZE_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output rem_stat_t         stat
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [SIZE_W-1:0] dvd_reg;
    logic [SIZE_W-1:0] dvd_next;
    logic [SIZE_W-1:0] dvs_reg;
    logic [SIZE_W-1:0] dvs_next;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   diff;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[SIZE_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[SIZE_W-2:0], 1'b0};
            rem_next  = diff[SIZE_W] ? shifted[SIZE_W-1:0] : diff[SIZE_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SIZE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

FILE: rtl/slab_block_free_list_allocator_top.sv
// Top level of the slab block free-list allocator: control, counters, stack and result register.
//
// Use: each request item on the req channel (valid/stall) is an allocate or a free, and it
// gives exactly one result item on the rsp channel (valid/stall). A free returns the index
// onto a LIFO stack; an allocate pops the most recently freed index, otherwise hands out
// the next never-used index, and reports the index and index times block_size.
// Items are handled one at a time. A free, or an allocate refused for its size or for a zero
// alignment, passes from acceptance through the execute and output states, and the next item
// is taken once its result is in the output register. An allocate that passes those checks
// first runs the bit-serial remainder unit (one bit per cycle over 32 bits) to test the
// alignment before those states; that unit sets the rate for allocations.
// The stack is a chain of 1024 cells that all shift together on a push or a pop.
// The user must write block_count and block_size through the cfg port only while no item
// is in flight; the block itself does not enforce it. Reset sets block_count to 1024 and
// block_size to 4096 and empties the stack and the never-used counter; the stack cells
// themselves are not cleared and need no sweep.
// When the receiver stalls, the finished result waits in the output register while the
// next request is accepted and worked on; that one then waits for the register to free.
module slab_block_free_list_allocator_top
    import sbfl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp
);

    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BLOCKS);
    localparam logic [BCNT_W-1:0] MAX_BCNT = BCNT_W'(MAX_BLOCKS);

    state_t            state_reg;
    state_t            state_next;
    logic [BCNT_W-1:0] block_count_reg;
    logic [BCNT_W-1:0] block_count_next;
    logic [SIZE_W-1:0] block_size_reg;
    logic [SIZE_W-1:0] block_size_next;
    logic [CNT_W-1:0]  freed_count_reg;
    logic [CNT_W-1:0]  freed_count_next;
    logic [CNT_W-1:0]  fresh_idx_reg;
    logic [CNT_W-1:0]  fresh_idx_next;
    req_t              req_reg;
    req_t              req_next;
    status_t           res_status_reg;
    status_t           res_status_next;
    logic [IDX_W-1:0]  res_index_reg;
    logic [IDX_W-1:0]  res_index_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              need_rem;
    logic              rem_start;
    logic              exec_en;
    logic              rsp_load;
    rem_stat_t         rem_stat;
    logic [CNT_W-1:0]  eff_count;
    logic [IDX_W-1:0]  stack_top;
    stk_op_t           dec_op;
    stk_op_t           stk_op;
    status_t           dec_status;
    logic [IDX_W-1:0]  dec_index;

    // An allocate that passes the zero, size and zero-alignment checks needs the remainder.
    assign need_rem = (req.opcode == OP_ALLOC) && (req.request_size != '0)
                   && (req.request_size <= block_size_reg) && (req.alignment != '0);

    // Effective block count: the configured count, capped at the slab capacity.
    assign eff_count = (block_count_reg > MAX_BCNT) ? MAX_CNT : CNT_W'(block_count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = need_rem ? S_REM : S_EXEC;
                end
            end
            S_REM:
            begin
                if (rem_stat.done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        req_stall = 1'b1;
        rem_start = 1'b0;
        exec_en   = 1'b0;
        rsp_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                rem_start = req_valid && need_rem;
            end
            S_EXEC:
            begin
                exec_en = 1'b1;
            end
            S_OUT:
            begin
                rsp_load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Alignment check: block_size modulo alignment.
    sbfl_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (block_size_reg),
        .divisor  (req.alignment),
        .stat     (rem_stat)
    );

    // Free-index stack.
    sbfl_stack u_stack
    (
        .clk       (clk),
        .op        (stk_op),
        .push_data (req_reg.free_index),
        .top_data  (stack_top)
    );

    // Decision for the held request, in the order the checks take precedence.
    always_comb
    begin
        dec_op         = STK_HOLD;
        dec_status     = ST_OK;
        dec_index      = '0;
        fresh_idx_next = fresh_idx_reg;
        freed_count_next = freed_count_reg;
        if (req_reg.opcode == OP_FREE)
        begin
            if ((CNT_W'(req_reg.free_index) >= eff_count) || (freed_count_reg >= MAX_CNT))
            begin
                dec_status = ST_BAD_FREE;
            end
            else
            begin
                dec_op           = STK_PUSH;
                dec_index        = req_reg.free_index;
                freed_count_next = freed_count_reg + 1'b1;
            end
        end
        else if (req_reg.request_size == '0)
        begin
            dec_status = ST_ZERO;
        end
        else if (req_reg.request_size > block_size_reg)
        begin
            dec_status = ST_SIZE;
        end
        else if ((req_reg.alignment == '0) || !rem_stat.zero)
        begin
            dec_status = ST_ALIGN;
        end
        else if (freed_count_reg != '0)
        begin
            dec_op           = STK_POP;
            dec_index        = stack_top;
            freed_count_next = freed_count_reg - 1'b1;
        end
        else if (fresh_idx_reg < eff_count)
        begin
            dec_index      = fresh_idx_reg[IDX_W-1:0];
            fresh_idx_next = fresh_idx_reg + 1'b1;
        end
        else
        begin
            dec_status = ST_EXHAUSTED;
        end
    end

    assign stk_op = exec_en ? dec_op : STK_HOLD;

    // Configuration writes and request capture.
    always_comb
    begin
        block_count_next = block_count_reg;
        block_size_next  = block_size_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_COUNT: block_count_next = cfg_data[BCNT_W-1:0];
                CFG_BLOCK_SIZE:  block_size_next  = cfg_data[SIZE_W-1:0];
                default:         block_count_next = block_count_reg;
            endcase
        end
        req_next = (!req_stall && req_valid) ? req : req_reg;
    end

    // Result assembly and the output register.
    always_comb
    begin
        res_status_next = exec_en ? dec_status : res_status_reg;
        res_index_next  = exec_en ? dec_index : res_index_reg;
        rsp_next        = rsp_reg;
        if (rsp_load)
        begin
            rsp_next.status       = res_status_reg;
            rsp_next.block_index  = res_index_reg;
            rsp_next.block_offset = OFF_W'(res_index_reg) * OFF_W'(block_size_reg);
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            block_count_reg <= BLOCK_COUNT_RESET;
            block_size_reg  <= BLOCK_SIZE_RESET;
            freed_count_reg <= '0;
            fresh_idx_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            block_count_reg <= block_count_next;
            block_size_reg  <= block_size_next;
            freed_count_reg <= exec_en ? freed_count_next : freed_count_reg;
            fresh_idx_reg   <= exec_en ? fresh_idx_next : fresh_idx_reg;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A pop is only issued while the stack holds entries.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (stk_op == STK_POP) |-> (freed_count_reg != '0))
        else $error("stack popped while empty");

    // Stack fill level and never-used counter stay within the slab.
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (freed_count_reg <= MAX_CNT) && (fresh_idx_reg <= MAX_CNT))
        else $error("allocator counter beyond slab capacity");

    // The remainder unit only finishes while the controller waits for it.
    a_rem_done_in_rem: assert property (@(posedge clk) disable iff (!rst_n)
        rem_stat.done |-> (state_reg == S_REM))
        else $error("remainder finished outside its wait state");

    // A refused request carries a zero index and offset.
    a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |-> ((rsp.block_index == '0)
                                               && (rsp.block_offset == '0)))
        else $error("refused result with nonzero index or offset");

    // A new result is loaded only after the previous one was taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("waiting result overwritten");

endmodule
